/* hw/rtl/trig_angle_range_reduction_assert.svh */
// Assertion macros shared by the range reduction RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef TRIG_ANGLE_RANGE_REDUCTION_ASSERT_SVH
`define TRIG_ANGLE_RANGE_REDUCTION_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, abandoned while reset is high.
`define TARR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define TARR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TARR_ASSERT(label, clk, rst, prop, msg)
`define TARR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* hw/rtl/tarr_pkg.sv */
package tarr_pkg;

  // pi * 2^60, truncated; pi at any fraction width is rounded from this
  localparam logic [63:0] PI_X60 = 64'h3243F6A8885A308D;

  typedef enum logic [1:0] {
    ACT_SIN  = 2'd0,
    ACT_COS  = 2'd1,
    ACT_TAN  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Control that travels beside the remainder through the pipeline
  typedef struct packed {
    logic    valid;
    action_t action;
    logic    q0;     // parity of the quotient by pi
  } tarr_ctl_t;

endpackage

/* hw/rtl/tarr_reduce_stage.sv */
`include "trig_angle_range_reduction_assert.svh"

module tarr_reduce_stage #(
  parameter int             UW   = 35,
  parameter logic [UW-1:0]  SUB  = '0,
  parameter bit             LAST = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  tarr_pkg::tarr_ctl_t ctl_in,
  input  logic [UW-1:0]       rem_in,
  output tarr_pkg::tarr_ctl_t ctl_out,
  output logic [UW-1:0]       rem_out
);
  import tarr_pkg::*;

  logic          take;
  logic [UW-1:0] diff;
  logic          valid;
  action_t       action;
  logic          q0;

  // Take off pi times this stage's power of two when it fits
  assign take = (rem_in >= SUB);
  assign diff = rem_in - SUB;

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl_in.valid;
    end
  end

  // Advance the payload; the last stage records the quotient parity
  always_ff @(posedge clk) begin
    action  <= ctl_in.action;
    q0      <= LAST ? take : ctl_in.q0;
    rem_out <= take ? diff : rem_in;
  end

  assign ctl_out = '{valid: valid, action: action, q0: q0};

  `TARR_ASSERT(a_rem_below_step, clk, rst, ctl_out.valid |-> (rem_out < SUB), "remainder not reduced below step")

endmodule

/* hw/rtl/tarr_fold.sv */
`include "trig_angle_range_reduction_assert.svh"

module tarr_fold #(
  parameter int            FB = 24,
  parameter int            HW = FB + 2,
  parameter logic [HW-1:0] PI = '0
) (
  input  logic                clk,
  input  logic                rst,
  input  tarr_pkg::tarr_ctl_t ctl_in,
  input  logic [HW-1:0]       h,
  output logic                done,
  output logic [FB:0]         reduced_angle,
  output logic                negate
);
  import tarr_pkg::*;

  logic [HW:0]   twice;
  logic [HW:0]   pi_ext;
  logic          gt;
  logic          ge;
  logic [HW-1:0] mirror_val;
  logic          mirror;
  logic          neg_next;
  logic          zero;
  logic [HW-1:0] res;

  // Compare 2h with pi exactly and form pi - h
  assign twice      = {h, 1'b0};
  assign pi_ext     = {1'b0, PI};
  assign gt         = (twice > pi_ext);
  assign ge         = (twice >= pi_ext);
  assign mirror_val = PI - h;

  // Pick the fold and the sign per function
  always_comb begin
    mirror   = 1'b0;
    neg_next = 1'b0;
    zero     = 1'b0;
    case (ctl_in.action)
      ACT_SIN: begin
        neg_next = ctl_in.q0 && (h != '0);
        mirror   = ge;
      end
      ACT_COS: begin
        neg_next = ctl_in.q0 ? !gt : gt;
        mirror   = ctl_in.q0 ? ge : gt;
      end
      ACT_TAN: begin
        neg_next = ge;
        mirror   = ge;
      end
      default: begin
        zero = 1'b1;
      end
    endcase
  end

  assign res = zero ? '0 : (mirror ? mirror_val : h);

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    reduced_angle <= res[FB:0];
    negate        <= neg_next;
  end

  `TARR_ASSERT(a_result_in_range, clk, rst, done |-> ({reduced_angle, 1'b0} <= PI), "reduced angle above pi/2")
  `TARR_ASSERT(a_unused_code_zero, clk, rst, (ctl_in.valid && (ctl_in.action == ACT_NONE)) |=> (done && (reduced_angle == '0) && !negate), "unused action gave nonzero result")

endmodule

/* hw/rtl/trig_angle_range_reduction.sv */
// Trigonometric argument range reduction.
// Channels: an item (angle, action) is taken on a rising edge with start high
// and busy low. angle is signed radians with FRAC_BITS fraction bits; action
// selects sine, cosine or tangent folding (the unused code gives zero). Each result (reduced_angle in
// [0, pi/2], negate) appears for exactly one cycle with done high.
// Pipeline: one offset stage, one conditional subtract of a shifted pi per
// quotient bit, one folding stage.
// Throughput: one item per cycle; the subtract chain is fully pipelined.
// Reset: busy is high while rst is high; all valid bits clear, so items in
// flight are dropped and done stays low until new items come through.
// The receiver cannot stall: results leave on a fixed schedule and busy is
// low whenever rst is low.
`include "trig_angle_range_reduction_assert.svh"

module trig_angle_range_reduction #(
  parameter int FRAC_BITS   = 24,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [ANGLE_WIDTH-1:0] angle,
  input  logic [1:0]             action,
  output logic                   done,
  output logic [FRAC_BITS:0]     reduced_angle,
  output logic                   negate
);
  import tarr_pkg::*;

  localparam logic [63:0] PI_Q64 =
    (PI_X60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  // Offset pi * 2^SHIFT is at least 2^(ANGLE_WIDTH-1) and a multiple of 2pi
  localparam int SHIFT   = (ANGLE_WIDTH - FRAC_BITS - 2 > 1) ?
                           (ANGLE_WIDTH - FRAC_BITS - 2) : 1;
  localparam int NSTEP   = SHIFT + 1;
  localparam int UW      = FRAC_BITS + SHIFT + 3;
  localparam int HW      = FRAC_BITS + 2;
  localparam int LATENCY = NSTEP + 2;
  localparam logic [UW-1:0] OFFSET = UW'(PI_Q64 << SHIFT);

  logic          accept;
  logic          in_valid;
  action_t       in_action;
  logic [UW-1:0] in_rem;
  tarr_ctl_t     ctl [0:NSTEP];
  logic [UW-1:0] rem [0:NSTEP];

  assign busy   = rst;
  assign accept = start && !busy;

  // Shift the angle up by the offset so it is never negative
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_action <= action_t'(action);
    in_rem    <= {{(UW - ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle} + OFFSET;
  end

  assign ctl[0] = '{valid: in_valid, action: in_action, q0: 1'b0};
  assign rem[0] = in_rem;

  // One quotient bit per stage, highest first
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    tarr_reduce_stage #(
      .UW   (UW),
      .SUB  (UW'(PI_Q64 << (SHIFT - i))),
      .LAST (i == NSTEP - 1)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[i]),
      .rem_in  (rem[i]),
      .ctl_out (ctl[i+1]),
      .rem_out (rem[i+1])
    );
  end

  // Fold the remainder below pi into [0, pi/2]
  tarr_fold #(
    .FB (FRAC_BITS),
    .HW (HW),
    .PI (HW'(PI_Q64))
  ) u_fold (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (ctl[NSTEP]),
    .h             (rem[NSTEP][HW-1:0]),
    .done          (done),
    .reduced_angle (reduced_angle),
    .negate        (negate)
  );

  `TARR_ASSERT(a_fixed_latency, clk, rst, accept |-> ##LATENCY done, "result missing after pipeline latency")
  `TARR_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !done, "result strobe after reset")
  `TARR_ASSERT(a_no_idle_result, clk, rst, (!accept && !in_valid && (ctl[NSTEP].valid == 1'b0)) |=> (done == 1'b0), "result without item at fold")

endmodule
